[hdl/ccol_pkg.sv]
// Shared types and constants for the concentration to HSV colour block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ccol_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ONE       = 1 << FRAC_BITS;
  localparam int unsigned CONC_W    = 32;
  localparam int unsigned HUE_W     = FRAC_BITS + 1;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 32;
  localparam int unsigned DIV_CNT_W = $clog2(FRAC_BITS);
  localparam int unsigned PROD_W    = 2 * (FRAC_BITS + 1);

  localparam logic [CONC_W-1:0] CONC_LIMIT_RST = CONC_W'(5000);

  localparam logic [CFG_IDX_W-1:0] REG_HUE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONC_LIMIT = 2'd2;

  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [FRAC_BITS:0]   frac1_t;

  typedef struct packed {
    logic              start;
    logic [CONC_W-1:0] num;
    logic [CONC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    frac_t quo;
  } div_rsp_t;

endpackage

`default_nettype wire

[hdl/ccol_div.sv]
// Restoring divider, one quotient bit per cycle: floor(num * 2^FRAC_BITS / den).
// Requires num < den. Depends on ccol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccol_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ccol_pkg::div_req_t req_i,
  output ccol_pkg::div_rsp_t rsp_o
);
  import ccol_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [CONC_W-1:0]    rem_q, rem_d;
  logic [CONC_W-1:0]    den_q, den_d;
  frac_t                quo_q, quo_d;
  logic [CONC_W:0]      rem_sh;
  logic [CONC_W:0]      rem_sub;
  logic                 fits;

  assign rem_sh  = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.num;
      den_d  = req_i.den;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[CONC_W-1:0] : rem_sh[CONC_W-1:0];
      quo_d = {quo_q[FRAC_BITS-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(FRAC_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

[hdl/ccol_mul.sv]
// Shared registered multiplier for the HSV products, one product per cycle.
// Depends on ccol_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ccol_mul (
  input  logic                          clk_i,
  input  ccol_pkg::frac1_t              a_i,
  input  ccol_pkg::frac1_t              b_i,
  output logic [ccol_pkg::PROD_W-1:0]   prod_o
);
  import ccol_pkg::*;

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

[hdl/concentration_to_hsv_colour.sv]
// Top level: config registers, running peak, sequencer around ccol_div and ccol_mul.
// Depends on ccol_pkg, ccol_div, ccol_mul.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, mode/first/conc   | to block
//  out     | out_valid_o, out_stall_i, red/green/blue/a| from block
//  cfg     | cfg_valid_i, cfg_ready_o, index, data     | to block
//
// Mode 0 word: updates the peak; the block stays idle and ready for the next word.
// Mode 1 word: divider (one bit a cycle), then the shared multiplier, then the output
//   register; zero scale or full concentration skips the divider.
// Reset: async active low, peak 0, hue 0, brightness 0, limit 5000.
// A new word is taken while a result waits; the next result waits on out_stall_i.
`timescale 1ns / 1ps
`default_nettype none

module concentration_to_hsv_colour (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               mode_i,
  input  logic                               first_i,
  input  logic [ccol_pkg::CONC_W-1:0]        concentration_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output ccol_pkg::frac_t                    red_o,
  output ccol_pkg::frac_t                    green_o,
  output ccol_pkg::frac_t                    blue_o,
  output ccol_pkg::frac_t                    alpha_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ccol_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ccol_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import ccol_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [2:0] MS_SF = 3'd0;
  localparam logic [2:0] MS_SG = 3'd1;
  localparam logic [2:0] MS_X  = 3'd2;
  localparam logic [2:0] MS_Y  = 3'd3;
  localparam logic [2:0] MS_Z  = 3'd4;
  localparam logic [2:0] MS_LAST = 3'd5;

  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  localparam int unsigned T_W = FRAC_BITS + 3;

  logic [HUE_W-1:0]  hue_q;
  frac_t             bright_q;
  logic [CONC_W-1:0] limit_q;
  logic [CONC_W-1:0] peak_q;

  logic [1:0] state_q, state_d;
  logic [2:0] step_q, step_d;
  frac_t      s_q, s_d;
  frac_t      sf_q, sf_d, sg_q, sg_d, x_q, x_d, y_q, y_d, z_q, z_d;

  logic  out_valid_q, out_valid_d;
  frac_t red_q, red_d, green_q, green_d, blue_q, blue_d, alpha_q, alpha_d;

  logic              in_acc;
  logic [CONC_W-1:0] scale;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  frac1_t            mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  frac_t             prod_hi;
  logic [HUE_W-1:0]  h_lim;
  logic [T_W-1:0]    t;
  logic [2:0]        sector;
  frac_t             f;
  logic              out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign scale       = (limit_q != '0) ? limit_q : peak_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign h_lim  = (hue_q > HUE_W'(ONE)) ? HUE_W'(ONE) : hue_q;
  assign t      = (T_W'(h_lim) << 2) + (T_W'(h_lim) << 1);
  assign sector = t[T_W-1:FRAC_BITS];
  assign f      = t[FRAC_BITS-1:0];

  assign prod_hi = prod[2*FRAC_BITS-1:FRAC_BITS];

  assign div_req.start = in_acc && mode_i && (scale != '0) && (concentration_i < scale);
  assign div_req.num   = concentration_i;
  assign div_req.den   = scale;

  ccol_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ccol_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_q)
      MS_SF: begin
        mul_a = {1'b0, s_q};
        mul_b = {1'b0, f};
      end
      MS_SG: begin
        mul_a = {1'b0, s_q};
        mul_b = frac1_t'(ONE) - {1'b0, f};
      end
      MS_X: begin
        mul_a = {1'b0, bright_q};
        mul_b = frac1_t'(ONE) - {1'b0, s_q};
      end
      MS_Y: begin
        mul_a = {1'b0, bright_q};
        mul_b = frac1_t'(ONE) - {1'b0, sf_q};
      end
      MS_Z: begin
        mul_a = {1'b0, bright_q};
        mul_b = frac1_t'(ONE) - {1'b0, sg_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    s_d         = s_q;
    sf_d        = sf_q;
    sg_d        = sg_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    out_valid_d = out_valid_q && out_stall_i;
    red_d       = red_q;
    green_d     = green_q;
    blue_d      = blue_q;
    alpha_d     = alpha_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && mode_i) begin
          step_d = MS_SF;
          if (scale == '0) begin
            s_d     = '0;
            state_d = ST_MUL;
          end else if (concentration_i >= scale) begin
            s_d     = frac_t'(ONE - 1);
            state_d = ST_MUL;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          s_d     = div_rsp.quo;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        step_d = step_q + 1'b1;
        case (step_q)
          MS_SG:   sf_d = prod_hi;
          MS_X:    sg_d = prod_hi;
          MS_Y:    x_d  = prod_hi;
          MS_Z:    y_d  = prod_hi;
          MS_LAST: begin
            z_d     = prod_hi;
            state_d = ST_DONE;
          end
          default: ;
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          alpha_d     = s_q;
          state_d     = ST_IDLE;
          case (sector)
            SEC_1: begin
              red_d = y_q; green_d = bright_q; blue_d = x_q;
            end
            SEC_2: begin
              red_d = x_q; green_d = bright_q; blue_d = z_q;
            end
            SEC_3: begin
              red_d = x_q; green_d = y_q; blue_d = bright_q;
            end
            SEC_4: begin
              red_d = z_q; green_d = x_q; blue_d = bright_q;
            end
            SEC_5: begin
              red_d = bright_q; green_d = x_q; blue_d = y_q;
            end
            default: begin
              red_d = bright_q; green_d = z_q; blue_d = x_q;
            end
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= MS_SF;
      out_valid_q <= 1'b0;
      hue_q       <= '0;
      bright_q    <= '0;
      limit_q     <= CONC_LIMIT_RST;
      peak_q      <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_HUE:        hue_q    <= cfg_data_i[HUE_W-1:0];
          REG_BRIGHTNESS: bright_q <= cfg_data_i[FRAC_BITS-1:0];
          REG_CONC_LIMIT: limit_q  <= cfg_data_i[CONC_W-1:0];
          default: ;
        endcase
      end
      if (in_acc && !mode_i && (first_i || concentration_i > peak_q)) begin
        peak_q <= concentration_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s_q     <= s_d;
    sf_q    <= sf_d;
    sg_q    <= sg_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
    alpha_q <= alpha_d;
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;

endmodule

`default_nettype wire

[hdl/ccol_checker.sv]
// Port-level assertions for concentration_to_hsv_colour, attached by bind.
// Depends on ccol_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none

module ccol_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           mode_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input ccol_pkg::frac_t                red_o,
  input ccol_pkg::frac_t                green_o,
  input ccol_pkg::frac_t                blue_o,
  input ccol_pkg::frac_t                alpha_o
);
  import ccol_pkg::*;

  // colouring word keeps the block busy
  a_busy_after_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i |=> in_stall_o)
    else $error("block not busy after colour word");

  // peak update leaves the block ready
  a_peak_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !mode_i |=> !in_stall_o)
    else $error("peak word held the block");

  // zero saturation gives grey
  a_grey_at_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (alpha_o == '0) |-> (red_o == green_o) && (green_o == blue_o))
    else $error("zero alpha word is not grey");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(red_o) && $stable(green_o) && $stable(blue_o)
      && $stable(alpha_o))
    else $error("output word changed while stalled");

endmodule

bind concentration_to_hsv_colour ccol_checker u_ccol_checker (.*);

`default_nettype wire

[dv/concentration_to_hsv_colour_test.sv]
// Self-checking bench for concentration_to_hsv_colour: directed table, then random bursts.
// Depends on ccol_pkg and the block; predicts peak, saturation and HSV colour per word.
`timescale 1ns / 1ps

module concentration_to_hsv_colour_test;
  import ccol_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 40;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int PHASE_WORDS    = 140;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic              mode;
    logic              first;
    logic [CONC_W-1:0] conc;
  } cell_word_t;

  typedef struct packed {
    frac_t red;
    frac_t green;
    frac_t blue;
    frac_t alpha;
  } colour_t;

  typedef enum logic [1:0] {ROW_REG, ROW_CELL, ROW_KNOWN} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DAT_W-1:0]  data;
    cell_word_t            word;
    colour_t               known;
  } dir_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic                  mode_i = 1'b0;
  logic                  first_i = 1'b0;
  logic [CONC_W-1:0]     concentration_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  frac_t                 red_o, green_o, blue_o, alpha_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]  cfg_data_i = '0;

  concentration_to_hsv_colour uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .mode_i, .first_i, .concentration_i,
    .out_valid_o, .out_stall_i, .red_o, .green_o, .blue_o, .alpha_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // predictor state
  logic [HUE_W-1:0]     hue_q = '0;
  frac_t                bright_q = '0;
  logic [CONC_W-1:0]    limit_q = CONC_LIMIT_RST;
  logic [CONC_W-1:0]    peak_q = '0;

  colour_t   colour_q[$];
  dir_row_t  dir_rows[$];

  int  mismatches = 0;
  int  cells_sent = 0;
  int  colours_seen = 0;
  int  reg_writes = 0;
  int  cycle_count = 0;
  int  idle_pct_in = 10;
  int  stall_pct_out = 71;
  bit  squeeze_req = 1'b0;
  bit  squeeze_done = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d colour words pending", cycle_count,
               colour_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [63:0] dim(input logic [63:0] v, input logic [63:0] k);
    logic [63:0] kk;
    kk = (k > ONE) ? 64'(ONE) : k;
    return (v * (64'(ONE) - kk)) >> FRAC_BITS;
  endfunction

  function automatic colour_t paint(input logic [CONC_W-1:0] c);
    logic [63:0] scale, coeff, s, h, t, f, v, x, y, z;
    logic [2:0]  sector;
    colour_t     col;
    scale = (limit_q != 0) ? 64'(limit_q) : 64'(peak_q);
    s = '0;
    if (scale != 0) begin
      coeff = (64'(c) < scale) ? 64'(c) : scale;
      s = (coeff << FRAC_BITS) / scale;
      if (s > ONE - 1) s = 64'(ONE - 1);
    end
    h = (hue_q > ONE) ? 64'(ONE) : 64'(hue_q);
    t = h * 6;
    sector = 3'(t >> FRAC_BITS);
    f = t & (ONE - 1);
    v = 64'(bright_q);
    x = dim(v, s);
    y = dim(v, (s * f) >> FRAC_BITS);
    z = dim(v, (s * (64'(ONE) - f)) >> FRAC_BITS);
    case (sector)
      3'd1: begin col.red = y[15:0]; col.green = v[15:0]; col.blue = x[15:0]; end
      3'd2: begin col.red = x[15:0]; col.green = v[15:0]; col.blue = z[15:0]; end
      3'd3: begin col.red = x[15:0]; col.green = y[15:0]; col.blue = v[15:0]; end
      3'd4: begin col.red = z[15:0]; col.green = x[15:0]; col.blue = v[15:0]; end
      3'd5: begin col.red = v[15:0]; col.green = x[15:0]; col.blue = y[15:0]; end
      default: begin col.red = v[15:0]; col.green = z[15:0]; col.blue = x[15:0]; end
    endcase
    col.alpha = s[15:0];
    return col;
  endfunction

  function automatic logic [CONC_W-1:0] pick_conc();
    logic [CONC_W-1:0] span;
    span = (limit_q != 0) ? limit_q : peak_q;
    if (span == 0) span = 100000;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      4: return span;
      default: return $urandom_range(0, span);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  always @(negedge clk_i) begin : check_colour
    colour_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      colours_seen++;
      if (colour_q.size() == 0) begin
        report_mismatch("colour word with none pending", 32'(red_o), 0);
      end else begin
        want = colour_q.pop_front();
        if (red_o !== want.red) report_mismatch("red", 32'(red_o), 32'(want.red));
        if (green_o !== want.green) report_mismatch("green", 32'(green_o), 32'(want.green));
        if (blue_o !== want.blue) report_mismatch("blue", 32'(blue_o), 32'(want.blue));
        if (alpha_o !== want.alpha) report_mismatch("alpha", 32'(alpha_o), 32'(want.alpha));
      end
    end
  end

  // receiver: random stall, plus one long hold-off when asked
  initial begin : receiver
    int held;
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !squeeze_done) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < SQUEEZE_CYCLES; held++) @(posedge clk_i);
        squeeze_done = 1'b1;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct_out);
    end
  end

  task automatic offer_cell(input cell_word_t w);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(0, 99) < idle_pct_in) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= w.mode;
    first_i <= w.first;
    concentration_i <= w.conc;
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    cells_sent++;
  endtask

  task automatic send_cell(input cell_word_t w);
    offer_cell(w);
    if (!w.mode) begin
      if (w.first || w.conc > peak_q) peak_q = w.conc;
    end else begin
      colour_q.push_back(paint(w.conc));
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
      @(posedge clk_i);
    end
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_HUE:        hue_q = data[HUE_W-1:0];
      REG_BRIGHTNESS: bright_q = data[FRAC_BITS-1:0];
      REG_CONC_LIMIT: limit_q = data;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    dir_row_t r;
    r.kind = ROW_REG; r.idx = idx; r.data = data; r.word = '0; r.known = '0;
    dir_rows.push_back(r);
  endtask

  task automatic add_cell(input logic m, input logic f, input logic [CONC_W-1:0] c);
    dir_row_t r;
    r.kind = ROW_CELL; r.idx = '0; r.data = '0; r.known = '0;
    r.word.mode = m; r.word.first = f; r.word.conc = c;
    dir_rows.push_back(r);
  endtask

  task automatic add_known(input logic [CONC_W-1:0] c, input frac_t rd, input frac_t gr,
                           input frac_t bl, input frac_t al);
    dir_row_t r;
    r.kind = ROW_KNOWN; r.idx = '0; r.data = '0;
    r.word.mode = 1'b1; r.word.first = 1'b0; r.word.conc = c;
    r.known.red = rd; r.known.green = gr; r.known.blue = bl; r.known.alpha = al;
    dir_rows.push_back(r);
  endtask

  task automatic random_settings();
    logic [CFG_DAT_W-1:0] d;
    d = $urandom & 32'hFFFE_0000;
    case ($urandom_range(0, 4))
      0: d |= 32'd0;
      1: d |= 32'(ONE);
      2: d |= 32'h1FFFF;
      3: d |= 32'($urandom_range(0, ONE - 1));
      default: d |= 32'($urandom_range(0, 2 * ONE - 1));
    endcase
    write_reg(REG_HUE, d);
    d = $urandom & 32'hFFFF_0000;
    case ($urandom_range(0, 3))
      0: d |= 32'd0;
      1: d |= 32'hFFFF;
      default: d |= 32'($urandom_range(0, ONE - 1));
    endcase
    write_reg(REG_BRIGHTNESS, d);
    case ($urandom_range(0, 5))
      0: d = '0;
      1: d = '1;
      2: d = $urandom;
      default: d = $urandom_range(1, 100000);
    endcase
    write_reg(REG_CONC_LIMIT, d);
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, $urandom);
  endtask

  initial begin : main
    cell_word_t w;
    dir_row_t   r;
    int         ph, sent, folds, paints, k;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: v = 0, limit 5000
    add_known(32'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    add_known(32'd5000, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    add_known(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    add_known(32'd2500, 16'd0, 16'd0, 16'd0, 16'd32768);
    // zero scale with empty peak gives grey at full value
    add_reg(REG_BRIGHTNESS, 32'hFFFF_FFFF);
    add_reg(REG_CONC_LIMIT, 32'd0);
    add_known(32'd123, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
    add_cell(1'b0, 1'b1, 32'd1000);
    add_cell(1'b0, 1'b0, 32'd400);
    add_cell(1'b0, 1'b0, 32'd4000);
    add_cell(1'b1, 1'b1, 32'd4000);
    add_cell(1'b1, 1'b0, 32'd1000);
    add_cell(1'b0, 1'b1, 32'd10);
    add_cell(1'b1, 1'b0, 32'd5);
    // one full turn, then above it
    add_reg(REG_HUE, 32'(ONE));
    add_cell(1'b1, 1'b0, 32'd7);
    add_reg(REG_HUE, 32'hFFFF_FFFF);
    add_cell(1'b1, 1'b1, 32'd3);
    add_reg(REG_HUE, 32'd10923);
    add_cell(1'b1, 1'b0, 32'd6);
    add_reg(REG_HUE, 32'd21846);
    add_cell(1'b1, 1'b0, 32'd4);
    add_reg(REG_HUE, 32'd32768);
    add_cell(1'b1, 1'b0, 32'd8);
    add_reg(REG_HUE, 32'd43691);
    add_cell(1'b1, 1'b0, 32'd2);
    add_reg(REG_HUE, 32'd54614);
    add_reg(REG_UNUSED, 32'hFFFF_FFFF);
    add_cell(1'b1, 1'b0, 32'd9);
    add_reg(REG_CONC_LIMIT, 32'hFFFF_FFFF);
    add_cell(1'b1, 1'b0, 32'hFFFF_FFFF);
    add_cell(1'b1, 1'b0, 32'h7FFF_FFFF);
    add_cell(1'b0, 1'b0, 32'hFFFF_FFFF);
    add_reg(REG_CONC_LIMIT, 32'd0);
    add_cell(1'b1, 1'b0, 32'hFFFF_FFFF);
    add_cell(1'b1, 1'b0, 32'd1);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      case (r.kind)
        ROW_REG: begin
          settle();
          write_reg(r.idx, r.data);
        end
        ROW_KNOWN: begin
          offer_cell(r.word);
          colour_q.push_back(r.known);
        end
        default: send_cell(r.word);
      endcase
    end

    for (ph = 0; ph < 6; ph++) begin
      settle();
      random_settings();
      if (ph < 2) begin
        idle_pct_in = 10; stall_pct_out = 71;
      end else if (ph < 4) begin
        idle_pct_in = 71; stall_pct_out = 10;
      end else begin
        idle_pct_in = 0; stall_pct_out = 0;
      end
      if (ph == 4) squeeze_req = 1'b1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(0, 9) == 0) begin
          w.mode = 1'($urandom_range(0, 1));
          w.first = 1'($urandom_range(0, 1));
          w.conc = $urandom;
          send_cell(w);
          sent++;
        end else begin
          // usually restart the peak, fold up to three words, then colour one to four cells
          folds = $urandom_range(0, 3);
          paints = $urandom_range(1, 4);
          for (k = 0; k < folds; k++) begin
            w.mode = 1'b0;
            w.first = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 3) == 0);
            w.conc = pick_conc();
            send_cell(w);
          end
          for (k = 0; k < paints; k++) begin
            w.mode = 1'b1;
            w.first = 1'($urandom_range(0, 1));
            w.conc = pick_conc();
            send_cell(w);
          end
          sent += folds + paints;
        end
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("summary: %0d cell words sent, %0d colour words checked, %0d register writes",
             cells_sent, colours_seen, reg_writes);
    $display("summary: six random phases with both idling mixes, no idling, one long hold-off");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
